>>> src/fsli_pkg.sv
// Shared types and sizes for the filtered sorted-list intersection unit.
// Used by filtered_sorted_list_intersection_unit; depends on nothing.
package fsli_pkg;

  localparam int unsigned DEPTH     = 32;
  localparam int unsigned USER_BITS = 19;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned CW        = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_W   = USER_BITS + 6;
  localparam int unsigned APB_AW    = 3;

  localparam logic CMD_LOAD_A = 1'b0;
  localparam logic CMD_LOAD_B = 1'b1;

  // Register index, taken from the word address of paddr.
  localparam logic REG_MAX_PARTITION = 1'b0;

  typedef struct packed {
    logic                 command;
    logic [USER_BITS-1:0] user_id;
    logic [2:0]           rating_value;
    logic [2:0]           rating_set;
    logic                 last_entry;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] rating_from_a;
    logic [2:0] rating_from_b;
    logic [5:0] match_count;
    logic       overflowed;
    logic       last_result;
  } out_beat_t;

endpackage

>>> src/fsli_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the two list stores.
module fsli_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/filtered_sorted_list_intersection_unit.sv
// Top level of the filtered sorted-list intersection unit: list loading,
// merge-walk sequencer, output register and APB register. Uses fsli_pkg, fsli_ram.
//
//   channel  | direction | handshake           | beat
//   ---------+-----------+---------------------+-----------------------------
//   in       | sink      | in_valid/in_ready   | in_beat_t (one list entry)
//   out      | source    | out_valid/out_ready | out_beat_t (match or summary)
//   apb      | sink      | psel/penable/pready | max_partition register
//
// The last B beat starts a merge walk in which each step is a RAM read state, then
// a user compare state, for at most 2*DEPTH-1 steps, then a closing range check in
// the read state and the summary state. The input is not ready during the walk.
// A stalled output holds the walk in its compare state on a match, or in the summary
// state. Reset clears both lengths and the overflow flag; the list stores hold no
// reset value.
module filtered_sorted_list_intersection_unit
  import fsli_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_beat_t          in_beat_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_beat_t         out_beat_o,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  output logic [31:0]       prdata_o,
  output logic              pready_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CW-1:0]      len_a_q, len_a_d, len_b_q, len_b_d;
  logic [CW-1:0]      idx_a_q, idx_a_d, idx_b_q, idx_b_d;
  logic [CW-1:0]      count_q, count_d;
  logic               ovf_q, ovf_d;
  logic [2:0]         max_part_q;
  logic               out_valid_q, out_valid_d;
  out_beat_t          out_q, out_d;

  logic               accept, full_a, full_b, we_a, we_b, out_free;
  logic [ENTRY_W-1:0] wr_entry, rd_a, rd_b;
  logic [USER_BITS-1:0] user_a, user_b;
  logic [2:0]         set_a, set_b;
  logic               a_less, hit;

  // APB register.
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[APB_AW-1] == REG_MAX_PARTITION) ? {29'd0, max_part_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_part_q <= 3'd1;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 paddr_i[APB_AW-1] == REG_MAX_PARTITION) begin
      max_part_q <= pwdata_i[2:0];
    end
  end

  // Loading.
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full_a     = (len_a_q == CW'(DEPTH));
  assign full_b     = (len_b_q == CW'(DEPTH));
  assign we_a       = accept && in_beat_i.command == CMD_LOAD_A && !full_a;
  assign we_b       = accept && in_beat_i.command == CMD_LOAD_B && !full_b;
  assign wr_entry   = {in_beat_i.user_id, in_beat_i.rating_value, in_beat_i.rating_set};

  fsli_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (len_a_q[AW-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (idx_a_q[AW-1:0]),
    .rdata_o (rd_a)
  );

  fsli_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (len_b_q[AW-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (idx_b_q[AW-1:0]),
    .rdata_o (rd_b)
  );

  // Entry fields: user id on top, then rating, then rating set.
  assign user_a   = rd_a[ENTRY_W-1 -: USER_BITS];
  assign user_b   = rd_b[ENTRY_W-1 -: USER_BITS];
  assign set_a    = rd_a[2:0];
  assign set_b    = rd_b[2:0];
  assign a_less   = (user_a < user_b);
  assign hit      = (user_a == user_b) && (set_a <= max_part_q) && (set_b <= max_part_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    len_a_d     = len_a_q;
    len_b_d     = len_b_q;
    idx_a_d     = idx_a_q;
    idx_b_d     = idx_b_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (we_a) begin
            len_a_d = len_a_q + CW'(1);
          end
          if (we_b) begin
            len_b_d = len_b_q + CW'(1);
          end
          if ((in_beat_i.command == CMD_LOAD_A && full_a) ||
              (in_beat_i.command == CMD_LOAD_B && full_b)) begin
            ovf_d = 1'b1;
          end
          if (in_beat_i.command == CMD_LOAD_B && in_beat_i.last_entry) begin
            idx_a_d = '0;
            idx_b_d = '0;
            count_d = '0;
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        // The RAMs capture the entries at idx_a_q and idx_b_q on this edge.
        if (idx_a_q < len_a_q && idx_b_q < len_b_q) begin
          state_d = ST_CMP;
        end else begin
          state_d = ST_SUM;
        end
      end
      ST_CMP: begin
        if (a_less) begin
          idx_a_d = idx_a_q + CW'(1);
          state_d = ST_RD;
        end else if (!hit || out_free) begin
          if (hit) begin
            out_valid_d         = 1'b1;
            out_d.rating_from_a = rd_a[5:3];
            out_d.rating_from_b = rd_b[5:3];
            out_d.match_count   = 6'd0;
            out_d.overflowed    = ovf_q;
            out_d.last_result   = 1'b0;
            count_d             = count_q + CW'(1);
          end
          idx_b_d = idx_b_q + CW'(1);
          state_d = ST_RD;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.rating_from_a = 3'd0;
          out_d.rating_from_b = 3'd0;
          out_d.match_count   = 6'(count_q);
          out_d.overflowed    = ovf_q;
          out_d.last_result   = 1'b1;
          len_a_d             = '0;
          len_b_d             = '0;
          ovf_d               = 1'b0;
          state_d             = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_a_q     <= '0;
      len_b_q     <= '0;
      idx_a_q     <= '0;
      idx_b_q     <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_a_q     <= len_a_d;
      len_b_q     <= len_b_d;
      idx_a_q     <= idx_a_d;
      idx_b_q     <= idx_b_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // Lists never grow past their store.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_a_q <= CW'(DEPTH) && len_b_q <= CW'(DEPTH))
    else $error("list length beyond store depth");

  // The walk never reads past the loaded part of either list.
  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> idx_a_q < len_a_q && idx_b_q < len_b_q)
    else $error("compare on an entry outside the list");

  // Each match consumes one B entry, so the count cannot run ahead of it.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> count_q <= idx_b_q)
    else $error("match count exceeds B entries walked");

  // Issuing the summary empties both lists and clears the overflow flag.
  a_sum_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SUM && out_free |=>
      len_a_q == '0 && len_b_q == '0 && !ovf_q && out_valid_q && out_q.last_result)
    else $error("summary did not end the run");

endmodule

>>> verif/filtered_sorted_list_intersection_unit_tb.sv
// Self-checking testbench for filtered_sorted_list_intersection_unit: loads rating lists,
// triggers merge walks and checks every match and summary beat against a local model.
// Depends on fsli_pkg and the unit itself.
module filtered_sorted_list_intersection_unit_tb
  import fsli_pkg::*;
();

  localparam int unsigned USER_MAX = (1 << USER_BITS) - 1;
  localparam int unsigned LIST_A = 0;
  localparam int unsigned LIST_B = 1;
  localparam logic [APB_AW-1:0] PARTITION_ADDR = {REG_MAX_PARTITION, 2'b00};

  typedef struct packed {
    logic [USER_BITS-1:0] user_id;
    logic [2:0]           rating;
    logic [2:0]           part;
  } list_entry_t;

  class intersection_scoreboard;
    list_entry_t lists[2][DEPTH];
    int unsigned lengths[2];
    bit          overflow;
    logic [2:0]  max_partition;
    out_beat_t   expected_q[$];
    int unsigned errors;

    function new();
      lengths[LIST_A] = 0;
      lengths[LIST_B] = 0;
      overflow = 1'b0;
      max_partition = 3'd1;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report_mismatch(input string what);
      errors++;
      $display("%0t: %s", $time, what);
    endtask

    // Stores one entry; the closing B beat runs the merge walk and queues its results.
    function void note_entry(input in_beat_t beat);
      int unsigned sel;
      int unsigned i;
      int unsigned j;
      logic [5:0]  count;
      list_entry_t a;
      list_entry_t b;
      out_beat_t   res;
      sel = (beat.command == CMD_LOAD_B) ? LIST_B : LIST_A;
      if (lengths[sel] >= DEPTH) begin
        overflow = 1'b1;
      end else begin
        lists[sel][lengths[sel]] = {beat.user_id, beat.rating_value, beat.rating_set};
        lengths[sel]++;
      end
      if (sel == LIST_B && beat.last_entry) begin
        i = 0;
        j = 0;
        count = '0;
        while (i < lengths[LIST_A] && j < lengths[LIST_B]) begin
          a = lists[LIST_A][i];
          b = lists[LIST_B][j];
          if (a.user_id < b.user_id) begin
            i++;
          end else begin
            if (a.user_id == b.user_id && a.part <= max_partition &&
                b.part <= max_partition) begin
              res = '0;
              res.rating_from_a = a.rating;
              res.rating_from_b = b.rating;
              res.overflowed = overflow;
              expected_q.push_back(res);
              count++;
            end
            j++;
          end
        end
        res = '0;
        res.match_count = count;
        res.overflowed = overflow;
        res.last_result = 1'b1;
        expected_q.push_back(res);
        lengths[LIST_A] = 0;
        lengths[LIST_B] = 0;
        overflow = 1'b0;
      end
    endfunction

    task check_result(input out_beat_t got);
      out_beat_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing expected", got));
      end else begin
        want = expected_q.pop_front();
        if (got.rating_from_a !== want.rating_from_a)
          report_mismatch($sformatf("rating_from_a got %0d want %0d",
                                    got.rating_from_a, want.rating_from_a));
        if (got.rating_from_b !== want.rating_from_b)
          report_mismatch($sformatf("rating_from_b got %0d want %0d",
                                    got.rating_from_b, want.rating_from_b));
        if (got.match_count !== want.match_count)
          report_mismatch($sformatf("match_count got %0d want %0d",
                                    got.match_count, want.match_count));
        if (got.overflowed !== want.overflowed)
          report_mismatch($sformatf("overflowed got %0b want %0b",
                                    got.overflowed, want.overflowed));
        if (got.last_result !== want.last_result)
          report_mismatch($sformatf("last_result got %0b want %0b",
                                    got.last_result, want.last_result));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_beat_t          in_beat = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_beat_t         out_beat;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  intersection_scoreboard sb;
  bit          idle_on = 1'b1;
  bit          hold_off_req = 1'b0;
  logic [2:0]  cur_partition = 3'd1;
  int unsigned items_sent = 0;

  filtered_sorted_list_intersection_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_beat_o (out_beat),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_o   (prdata),
    .pready_o   (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #(8 * 300000);
    $display("filtered_sorted_list_intersection_unit_tb NOT OK");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_entry(in_beat);
      if (out_valid && out_ready) sb.check_result(out_beat);
    end
  end

  // Output side: random stalls, plus one long hold-off that backs up the walk.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        out_ready <= !idle_on || ($urandom_range(0, 99) >= 23);
      end
    end
  end

  function automatic logic [2:0] pick_part();
    if ($urandom_range(0, 99) < 60) return 3'($urandom_range(0, cur_partition));
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t beat;
    beat.command = $urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A;
    beat.user_id = $urandom_range(0, 1) ? USER_BITS'($urandom_range(0, USER_MAX))
                                        : USER_BITS'($urandom_range(0, 15));
    beat.rating_value = 3'($urandom_range(0, 7));
    beat.rating_set = pick_part();
    beat.last_entry = ($urandom_range(0, 9) == 0);
    return beat;
  endfunction

  // Called on a rising edge; returns on the edge at which the beat is taken.
  task automatic send_entry(input in_beat_t beat);
    if (idle_on && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 30);
    end
    in_valid <= 1'b1;
    in_beat <= beat;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_fields(input logic cmd, input int unsigned user, input int unsigned rating,
                             input int unsigned part, input logic last);
    in_beat_t beat;
    beat.command = cmd;
    beat.user_id = USER_BITS'(user);
    beat.rating_value = 3'(rating);
    beat.rating_set = 3'(part);
    beat.last_entry = last;
    send_entry(beat);
  endtask

  // One well-formed run: ascending unique ids drawn from a common pool, so that
  // the two lists overlap; optionally broken by a swap and a repeated id.
  task automatic send_run(input int unsigned pool_n, input int unsigned max_step,
                          input int unsigned both_pct, input bit scramble);
    in_beat_t    a_q[$];
    in_beat_t    b_q[$];
    in_beat_t    beat;
    in_beat_t    tmp;
    int unsigned span;
    int unsigned id;
    int unsigned k;
    int unsigned r;
    span = pool_n * max_step;
    id = (span < USER_MAX) ? $urandom_range(0, USER_MAX - span) : 0;
    for (k = 0; k < pool_n && id + max_step <= USER_MAX; k++) begin
      id = id + $urandom_range(1, max_step);
      r = $urandom_range(0, 99);
      beat.user_id = USER_BITS'(id);
      beat.rating_value = 3'($urandom_range(0, 7));
      beat.rating_set = pick_part();
      beat.last_entry = 1'b0;
      if (r < both_pct) begin
        beat.command = CMD_LOAD_A;
        a_q.push_back(beat);
        beat.command = CMD_LOAD_B;
        beat.rating_value = 3'($urandom_range(0, 7));
        beat.rating_set = pick_part();
        b_q.push_back(beat);
      end else if (r % 2) begin
        beat.command = CMD_LOAD_A;
        a_q.push_back(beat);
      end else begin
        beat.command = CMD_LOAD_B;
        b_q.push_back(beat);
      end
    end
    if (b_q.size() == 0) begin
      beat = random_beat();
      beat.command = CMD_LOAD_B;
      b_q.push_back(beat);
    end
    if (scramble && b_q.size() > 1) begin
      tmp = b_q[0];
      b_q[0] = b_q[b_q.size() - 1];
      b_q[b_q.size() - 1] = tmp;
    end
    if (scramble && a_q.size() > 0) a_q.push_back(a_q[0]);
    if (a_q.size() > 0) begin
      tmp = a_q[a_q.size() - 1];
      tmp.last_entry = 1'b1;
      a_q[a_q.size() - 1] = tmp;
    end
    tmp = b_q[b_q.size() - 1];
    tmp.last_entry = 1'b1;
    b_q[b_q.size() - 1] = tmp;
    // A and B loads may interleave; only the closing B beat must come last.
    while (a_q.size() > 0 || b_q.size() > 1) begin
      if (b_q.size() <= 1 || (a_q.size() > 0 && $urandom_range(0, 1)))
        send_entry(a_q.pop_front());
      else
        send_entry(b_q.pop_front());
    end
    send_entry(b_q.pop_front());
  endtask

  task automatic send_noise(input int unsigned n);
    in_beat_t beat;
    repeat (n) send_entry(random_beat());
    beat = random_beat();
    beat.command = CMD_LOAD_B;
    beat.last_entry = 1'b1;
    send_entry(beat);
  endtask

  task automatic write_partition(input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PARTITION_ADDR;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.max_partition = 3'(value);
    cur_partition = 3'(value);
  endtask

  // The first edge lets the monitor take in the beat accepted on the current one.
  task automatic wait_drained();
    int unsigned n;
    n = 0;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int unsigned settings[5];
    int unsigned phase;
    int unsigned phase_end;
    int unsigned r;
    sb = new();
    settings[0] = 7;
    settings[1] = 0;
    settings[2] = 5;
    settings[3] = 3;
    settings[4] = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty A list: only a summary with a zero count.
    send_fields(CMD_LOAD_B, 100, 3, 1, 1'b1);
    // Extreme ids and ratings, with last_entry on the A list as well.
    send_fields(CMD_LOAD_A, 0, 7, 0, 1'b0);
    send_fields(CMD_LOAD_A, USER_MAX, 0, 1, 1'b1);
    send_fields(CMD_LOAD_B, 0, 0, 1, 1'b0);
    send_fields(CMD_LOAD_B, USER_MAX, 7, 0, 1'b1);
    // Equal users filtered out by their rating sets.
    send_fields(CMD_LOAD_A, 20, 5, 2, 1'b0);
    send_fields(CMD_LOAD_A, 30, 1, 1, 1'b1);
    send_fields(CMD_LOAD_B, 10, 2, 0, 1'b0);
    send_fields(CMD_LOAD_B, 20, 4, 1, 1'b0);
    send_fields(CMD_LOAD_B, 30, 6, 2, 1'b1);
    // Unsorted and repeated ids.
    send_fields(CMD_LOAD_A, 9, 1, 0, 1'b0);
    send_fields(CMD_LOAD_A, 4, 2, 1, 1'b0);
    send_fields(CMD_LOAD_A, 4, 3, 0, 1'b0);
    send_fields(CMD_LOAD_B, 4, 5, 0, 1'b0);
    send_fields(CMD_LOAD_B, 9, 6, 1, 1'b0);
    send_fields(CMD_LOAD_B, 9, 7, 0, 1'b1);
    // Highest rating set.
    send_fields(CMD_LOAD_A, 'h2AAAA, 5, 7, 1'b1);
    send_fields(CMD_LOAD_B, 'h2AAAA, 2, 7, 1'b1);

    for (phase = 0; phase < 8; phase++) begin
      wait_drained();
      idle_on = (phase != 2);
      write_partition(phase < 5 ? settings[phase] : $urandom_range(0, 7));
      if (phase == 3) hold_off_req = 1'b1;
      // Both lists past their depth.
      if (phase == 0) send_run(38, 13000, 100, 1'b0);
      phase_end = items_sent + 25;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 12)
          send_noise($urandom_range(2, 10));
        else if (r < 20)
          send_run($urandom_range(28, 38), $urandom_range(1, 13000), 100, 1'b0);
        else
          send_run($urandom_range(1, 12), (r % 2) ? 3 : 14000, 60, r < 30);
      end
    end

    wait_drained();
    if (sb.pending() != 0) sb.report_mismatch("results still expected at end of run");
    if (sb.errors == 0) begin
      $display("filtered_sorted_list_intersection_unit_tb OK");
    end else begin
      $display("filtered_sorted_list_intersection_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
